>>> rtl/core/mbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbb_pkg;

    // frame buffer word geometry
    localparam int WORD_LOG2      = 5;
    localparam int WORD_BITS      = 1 << WORD_LOG2;
    localparam int WORDS_PER_LINE = 20;

    // fixed field widths
    localparam int ADDR_BITS  = 13;
    localparam int FIELD_BITS = 32;
    localparam int DX_BITS    = 10;
    localparam int DY_BITS    = 9;
    localparam int WW_BITS    = 5;
    localparam int HR_BITS    = 9;

    // apb
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    // register indexes
    localparam logic [1:0] REG_DEST_X      = 2'd0;
    localparam logic [1:0] REG_DEST_Y      = 2'd1;
    localparam logic [1:0] REG_WIDTH_WORDS = 2'd2;
    localparam logic [1:0] REG_HEIGHT_ROWS = 2'd3;

    // queue between front and back
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

    typedef struct packed {
        logic [WORD_BITS-1:0] src;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_LOG2-1:0] off;
        logic                 done;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/mbb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mbb_front import mbb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    input  wire logic                  s_valid,
    input  wire logic [FIELD_BITS-1:0] s_source_word,
    output logic                       s_ready,
    input  wire logic                  q_full,
    output logic                       q_push,
    output entry_t                     q_entry
);

    logic [DX_BITS-1:0]   dest_x_reg, dest_x_next;
    logic [DY_BITS-1:0]   dest_y_reg, dest_y_next;
    logic [WW_BITS-1:0]   width_reg, width_next;
    logic [HR_BITS-1:0]   height_reg, height_next;
    logic [WW_BITS-1:0]   col_reg, col_next;
    logic [HR_BITS-1:0]   row_reg, row_next;
    logic [ADDR_BITS-1:0] rsa_reg, rsa_next;
    logic                 cfg_wr;
    logic                 accept;
    logic                 last_col;
    logic                 last_row;
    logic [1:0]           reg_index;

    function automatic logic [ADDR_BITS-1:0] start_addr(
        input logic [DX_BITS-1:0] x,
        input logic [DY_BITS-1:0] y
    );
        return ADDR_BITS'(ADDR_BITS'(y) * ADDR_BITS'(WORDS_PER_LINE)
                          + ADDR_BITS'(x >> WORD_LOG2));
    endfunction

    assign reg_index = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    // zero width or height compares as one
    assign last_col = (({1'b0, col_reg} + (WW_BITS+1)'(1)) >= {1'b0, width_reg});
    assign last_row = (({1'b0, row_reg} + (HR_BITS+1)'(1)) >= {1'b0, height_reg});

    always_comb begin
        q_entry.src  = s_source_word[WORD_BITS-1:0];
        q_entry.addr = ADDR_BITS'(rsa_reg + ADDR_BITS'(col_reg));
        q_entry.off  = dest_x_reg[WORD_LOG2-1:0];
        q_entry.done = last_col && last_row;
    end

    always_comb begin
        unique case (reg_index)
            REG_DEST_X:      prdata = PDATA_BITS'(dest_x_reg);
            REG_DEST_Y:      prdata = PDATA_BITS'(dest_y_reg);
            REG_WIDTH_WORDS: prdata = PDATA_BITS'(width_reg);
            REG_HEIGHT_ROWS: prdata = PDATA_BITS'(height_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        dest_x_next = dest_x_reg;
        dest_y_next = dest_y_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            unique case (reg_index)
                REG_DEST_X:      dest_x_next = pwdata[DX_BITS-1:0];
                REG_DEST_Y:      dest_y_next = pwdata[DY_BITS-1:0];
                REG_WIDTH_WORDS: width_next  = pwdata[WW_BITS-1:0];
                REG_HEIGHT_ROWS: height_next = pwdata[HR_BITS-1:0];
                default:         dest_x_next = dest_x_reg;
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        rsa_next = rsa_reg;
        priority if (cfg_wr) begin
            // any register write restarts the blit
            col_next = '0;
            row_next = '0;
            rsa_next = start_addr(dest_x_next, dest_y_next);
        end else if (accept) begin
            priority if (!last_col) begin
                col_next = col_reg + WW_BITS'(1);
            end else if (!last_row) begin
                col_next = '0;
                row_next = row_reg + HR_BITS'(1);
                rsa_next = ADDR_BITS'(rsa_reg + ADDR_BITS'(WORDS_PER_LINE));
            end else begin
                col_next = '0;
                row_next = '0;
                rsa_next = start_addr(dest_x_reg, dest_y_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            width_reg  <= WW_BITS'(1);
            height_reg <= HR_BITS'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            rsa_reg    <= '0;
        end else begin
            dest_x_reg <= dest_x_next;
            dest_y_reg <= dest_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            rsa_reg    <= rsa_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mbb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mbb_queue import mbb_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  entry_t    push_entry,
    output logic      full,
    output logic      head_valid,
    output entry_t    head_entry,
    input  wire logic pop
);

    entry_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mbb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mbb_back import mbb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  entry_t                     q_entry,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [ADDR_BITS-1:0]  m_write_address,
    output logic      [FIELD_BITS-1:0] m_write_data,
    output logic      [FIELD_BITS-1:0] m_write_mask,
    output logic                       m_last_of_item,
    output logic                       m_blit_done
);

    localparam logic [WORD_LOG2:0] WORD_BITS_W = (WORD_LOG2+1)'(WORD_BITS);

    logic                  valid_reg, valid_next;
    logic                  phase_reg, phase_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [FIELD_BITS-1:0] data_reg, data_next;
    logic [FIELD_BITS-1:0] mask_reg, mask_next;
    logic                  last_reg, last_next;
    logic                  done_reg, done_next;
    logic                  out_free;
    logic                  aligned;
    logic [WORD_LOG2:0]    lsh;
    logic [WORD_BITS-1:0]  full_w;
    logic [WORD_BITS-1:0]  m1;
    logic [WORD_BITS-1:0]  m2;
    logic [WORD_BITS-1:0]  d1;
    logic [WORD_BITS-1:0]  d2;

    assign full_w   = {WORD_BITS{1'b1}};
    assign aligned  = (q_entry.off == '0);
    assign lsh      = WORD_BITS_W - {1'b0, q_entry.off};
    assign m1       = full_w >> q_entry.off;
    assign m2       = ~m1;
    assign d1       = q_entry.src >> q_entry.off;
    assign d2       = q_entry.src << lsh;
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        mask_next  = mask_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        q_pop      = 1'b0;
        if (out_free) begin
            valid_next = q_valid;
            if (q_valid) begin
                priority if (aligned) begin
                    addr_next = q_entry.addr;
                    data_next = FIELD_BITS'(q_entry.src);
                    mask_next = FIELD_BITS'(full_w);
                    last_next = 1'b1;
                    done_next = q_entry.done;
                    q_pop     = 1'b1;
                end else if (!phase_reg) begin
                    addr_next  = q_entry.addr;
                    data_next  = FIELD_BITS'(d1);
                    mask_next  = FIELD_BITS'(m1);
                    last_next  = 1'b0;
                    done_next  = 1'b0;
                    phase_next = 1'b1;
                end else begin
                    addr_next  = ADDR_BITS'(q_entry.addr + ADDR_BITS'(1));
                    data_next  = FIELD_BITS'(d2 & m2);
                    mask_next  = FIELD_BITS'(m2);
                    last_next  = 1'b1;
                    done_next  = q_entry.done;
                    phase_next = 1'b0;
                    q_pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        data_reg <= data_next;
        mask_reg <= mask_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_valid         = valid_reg;
    assign m_write_address = addr_reg;
    assign m_write_data    = data_reg;
    assign m_write_mask    = mask_reg;
    assign m_last_of_item  = last_reg;
    assign m_blit_done     = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/masked_bitmap_blit_core.sv
// masked bitmap blit core: address and shift stage of a monochrome blitter
// the apb port sets dest_x, dest_y, width_words and height_rows (byte
// addresses 0, 4, 8, 12); any register write restarts the blit
// the s_ channel takes one source word per transfer in row order, msb first
// the m_ channel gives masked frame buffer writes: one full-mask write per
// word when dest_x is word aligned, else two (word shifted right into the
// first frame word, shifted left into the next)
// the first write of a word goes through a queue slot and then the output
// register before it is on m_
// one word per cycle when aligned and m_ready is high; an unaligned word
// takes two writes, set by the single write output register of the back end
// a two-entry queue parts the front (counters, addressing) from the back
// (shift and mask), so s_ready stays high while a write waits on m_ready
// and drops only once the queue is full
// reset (aresetn low, synchronous) empties the queue, drops m_valid and
// loads the registers with 0, 0, 1, 1 and the cursor with the blit start
// a stalled receiver holds m_ outputs steady until the transfer completes
`timescale 1ns / 1ps
`default_nettype none

module masked_bitmap_blit_core import mbb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready,
    // source words
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FIELD_BITS-1:0] s_source_word,
    // frame buffer writes
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [ADDR_BITS-1:0]  m_write_address,
    output logic      [FIELD_BITS-1:0] m_write_data,
    output logic      [FIELD_BITS-1:0] m_write_mask,
    output logic                       m_last_of_item,
    output logic                       m_blit_done
);

    // front to queue
    logic   q_push;
    logic   q_full;
    entry_t q_in;
    // queue to back
    logic   q_valid;
    logic   q_pop;
    entry_t q_head;

    // zero wait state apb
    assign pready = 1'b1;

    // counters and address generation, one source word per cycle while the queue is not full
    mbb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_valid       (s_valid),
        .s_source_word (s_source_word),
        .s_ready       (s_ready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    // classified words waiting for the write port
    mbb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    // shift and mask, one write per cycle while m_ready is high
    mbb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_write_mask    (m_write_mask),
        .m_last_of_item  (m_last_of_item),
        .m_blit_done     (m_blit_done)
    );

endmodule

`default_nettype wire

>>> rtl/core/mbb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mbb_checker import mbb_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [ADDR_BITS-1:0]  m_write_address,
    input wire logic [FIELD_BITS-1:0] m_write_data,
    input wire logic [FIELD_BITS-1:0] m_write_mask,
    input wire logic                  m_last_of_item,
    input wire logic                  m_blit_done
);

    // stalled write stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    // stalled write keeps its address
    a_hold_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_write_address))
        else $error("write address changed while stalled");

    // end of blit is always the last write of its word
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blit_done |-> m_last_of_item)
        else $error("blit done without last of item");

    // data stays inside the mask
    a_data_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_write_data & ~m_write_mask) == '0))
        else $error("write data outside mask");

    // a first half write is followed by its second half at the next address
    a_pair_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_item |=>
            !m_valid || (m_write_address == ADDR_BITS'($past(m_write_address) + 1'b1)))
        else $error("second half write at wrong address");

endmodule

bind masked_bitmap_blit_core mbb_checker u_mbb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_write_address (m_write_address),
    .m_write_data    (m_write_data),
    .m_write_mask    (m_write_mask),
    .m_last_of_item  (m_last_of_item),
    .m_blit_done     (m_blit_done)
);

`default_nettype wire
